// ===== hdl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Widths, defaults, request kinds, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_COLS_DEF   = 64;
   localparam int MAX_ROWS_DEF   = 64;
   localparam int ELEM_WIDTH_DEF = 16;

   localparam int KIND_W    = 2;
   localparam int IDX_W     = 12;
   localparam int CFG_W     = 7;
   localparam int ROW_W     = 6;
   localparam int ACC_W     = 40;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] NUM_COLS_RESET = 7'd64;
   localparam logic [CFG_W-1:0] NUM_ROWS_RESET = 7'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_MATRIX = 2'd0,
      KIND_LOAD_VECTOR = 2'd1,
      KIND_COMPUTE     = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_COLS = 1'b0,
      CSR_NUM_ROWS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2
   } state_type;

endpackage

// ===== hdl/mvm_req_if.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply request channel
// Valid/ready channel carrying load and compute requests.
// ----------------------------------------------------------------------------
interface mvm_req_if #(
   parameter int ElemWidth = mvm_pkg::ELEM_WIDTH_DEF
);
   import mvm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [KIND_W-1:0]           kind;
   logic [IDX_W-1:0]            index;
   logic signed [ElemWidth-1:0] value;

   modport source (output valid, kind, index, value, input ready);
   modport sink   (input valid, kind, index, value, output ready);
endinterface

// ===== hdl/mvm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply response channel
// Valid/ready channel carrying one row dot product per transfer.
// ----------------------------------------------------------------------------
interface mvm_rsp_if;
   import mvm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        row;
   logic signed [ACC_W-1:0] dot;
   logic                    last;

   modport source (output valid, row, dot, last, input ready);
   modport sink   (input valid, row, dot, last, output ready);
endinterface

// ===== hdl/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
   parameter int Width = 16,
   parameter int Depth = 64,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply
// Stores a row-major matrix and a vector; a compute request returns one
// exact signed 40-bit dot product per row, in row order, through one shared MAC.
// ----------------------------------------------------------------------------
//  channel  | direction | transfer
//  req_bus  | in        | load matrix element, load vector element, compute
//  rsp_bus  | out       | row, dot, last (one per row)
//  csr_*    | in        | write num_cols / num_rows
//
//  A compute issues rows*cols MACs, one per cycle unless rsp_bus stalls,
//  through the single multiplier and the matrix RAM read port, then drains
//  the s1 and s2 pipeline registers; req_bus is not ready meanwhile.
//  A held result on rsp_bus stalls the whole MAC pipeline.
//  Reset is synchronous; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
   parameter int MAX_COLS   = mvm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = mvm_pkg::MAX_ROWS_DEF,
   parameter int ELEM_WIDTH = mvm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   mvm_req_if.sink                        req_bus,
   mvm_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mvm_pkg::CFG_W-1:0]      csr_wdata
);
   import mvm_pkg::*;

   localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int PROD_W    = 2 * ELEM_WIDTH;
   localparam int AREA_W    = 2 * CFG_W;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_col;
      logic             last_row;
      logic [RW-1:0]    row;
   } tag_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] num_cols_ff, num_rows_ff;
   logic [CFG_W-1:0] cols_eff, rows_eff;
   logic [AREA_W-1:0] area;

   logic [MAT_AW-1:0] mat_addr_ff, mat_addr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              last_col, last_row;

   logic issue, stall, req_fire, mat_we, vec_we;
   logic [MAT_AW+IDX_W-1:0] mat_wr_wide;
   logic [COL_W+IDX_W-1:0]  vec_wr_wide;
   logic [ELEM_WIDTH-1:0]   mat_rd_data, vec_rd_data;

   tag_type s1_ff, s1_in, s2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_sum;

   logic                    rsp_valid_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic signed [ACC_W-1:0] rsp_dot_ff;
   logic                    rsp_last_ff;
   logic [RW+ROW_W-1:0]     row_wide;

   // size clamp and load range check
   always_comb begin
      if (num_cols_ff == '0) begin
         cols_eff = CFG_W'(1);
      end else if (32'(num_cols_ff) > MAX_COLS) begin
         cols_eff = CFG_W'(MAX_COLS);
      end else begin
         cols_eff = num_cols_ff;
      end
      if (num_rows_ff == '0) begin
         rows_eff = CFG_W'(1);
      end else if (32'(num_rows_ff) > MAX_ROWS) begin
         rows_eff = CFG_W'(MAX_ROWS);
      end else begin
         rows_eff = num_rows_ff;
      end
   end

   assign area = AREA_W'(cols_eff) * AREA_W'(rows_eff);

   assign req_fire    = req_bus.valid & req_bus.ready;
   assign mat_we      = req_fire & (req_bus.kind == KIND_LOAD_MATRIX)
                        & (32'(req_bus.index) < 32'(area));
   assign vec_we      = req_fire & (req_bus.kind == KIND_LOAD_VECTOR)
                        & (32'(req_bus.index) < 32'(cols_eff));
   assign mat_wr_wide = (MAT_AW+IDX_W)'(req_bus.index);
   assign vec_wr_wide = (COL_W+IDX_W)'(req_bus.index);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= NUM_COLS_RESET;
         num_rows_ff <= NUM_ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_COLS: num_cols_ff <= csr_wdata;
            CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   assign stall    = rsp_valid_ff & ~rsp_bus.ready;
   assign last_col = (32'(col_ff) + 32'd1) == 32'(cols_eff);
   assign last_row = (32'(row_ff) + 32'd1) == 32'(rows_eff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.kind == KIND_COMPUTE) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue && last_col && last_row) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff.valid && !s2_ff.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      issue         = 1'b0;
      case (state_ff)
         ST_IDLE:  req_bus.ready = 1'b1;
         ST_RUN:   issue = ~stall;
         ST_DRAIN: ;
         default:  ;
      endcase
   end

   always_comb begin
      mat_addr_in = mat_addr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (req_fire) begin
         mat_addr_in = '0;
         col_in      = '0;
         row_in      = '0;
      end else if (issue) begin
         mat_addr_in = mat_addr_ff + MAT_AW'(1);
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mat_addr_ff <= mat_addr_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
   end

   mvm_ram #(.Width(ELEM_WIDTH), .Depth(MAT_DEPTH)) u_matrix_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wr_wide[MAT_AW-1:0]),
      .wr_data (req_bus.value),
      .rd_en   (issue),
      .rd_addr (mat_addr_ff),
      .rd_data (mat_rd_data)
   );

   mvm_ram #(.Width(ELEM_WIDTH), .Depth(MAX_COLS)) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (vec_wr_wide[COL_W-1:0]),
      .wr_data (req_bus.value),
      .rd_en   (issue),
      .rd_addr (col_ff),
      .rd_data (vec_rd_data)
   );

   // MAC pipeline: read, multiply, accumulate
   always_comb begin
      s1_in.valid    = issue;
      s1_in.first    = (col_ff == '0);
      s1_in.last_col = last_col;
      s1_in.last_row = last_row;
      s1_in.row      = row_ff;
   end

   assign acc_sum = (s2_ff.first ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (!stall) begin
         s1_ff.valid <= s1_in.valid;
         s2_ff.valid <= s1_ff.valid;
      end
      if (!stall) begin
         s1_ff.first    <= s1_in.first;
         s1_ff.last_col <= s1_in.last_col;
         s1_ff.last_row <= s1_in.last_row;
         s1_ff.row      <= s1_in.row;
         s2_ff.first    <= s1_ff.first;
         s2_ff.last_col <= s1_ff.last_col;
         s2_ff.last_row <= s1_ff.last_row;
         s2_ff.row      <= s1_ff.row;
         prod_ff        <= $signed(mat_rd_data) * $signed(vec_rd_data);
         if (s2_ff.valid) begin
            acc_ff <= acc_sum;
         end
      end
   end

   // result register
   assign row_wide = (RW+ROW_W)'(s2_ff.row);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!stall) begin
         rsp_valid_ff <= s2_ff.valid & s2_ff.last_col;
      end
      if (!stall && s2_ff.valid && s2_ff.last_col) begin
         rsp_row_ff  <= row_wide[ROW_W-1:0];
         rsp_dot_ff  <= acc_sum;
         rsp_last_ff <= s2_ff.last_row;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.row   = rsp_row_ff;
   assign rsp_bus.dot   = rsp_dot_ff;
   assign rsp_bus.last  = rsp_last_ff;
endmodule
